>>> rtl/fedl_pkg.sv
// Shared constants, register codes and control types for the feedback echo delay line.
package fedl_pkg;

  localparam int SMP_W     = 32;
  localparam int MAX_DELAY = 65536;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int LEN_W     = 17;
  localparam int PCT_W     = 7;
  localparam int CFG_W     = 17;
  localparam int REG_IDX_W = 2;
  localparam int NSTG      = 6;

  localparam logic [REG_IDX_W-1:0] REG_DELAY_LENGTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_PERCENT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_ENABLE      = 2'd2;

  localparam logic [LEN_W-1:0] DELAY_LENGTH_RST     = 17'd0;
  localparam logic [PCT_W-1:0] FEEDBACK_PERCENT_RST = 7'd33;
  localparam logic             ECHO_ENABLE_RST      = 1'b1;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DELAY);

  // n / 100 = (n * DIV_MAGIC) >> DIV_SHIFT for any 32-bit n
  localparam int DIV_MAGIC_W = 31;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 31'd1374389535;
  localparam int DIV_SHIFT = 37;
  localparam int Q_W       = 25;
  localparam int DIV_PROD_W = SMP_W + DIV_MAGIC_W;

  // x / 100 = (x * SDIV_MAGIC) >> SDIV_SHIFT for x below 43699
  localparam int RP_W       = 14;
  localparam int SDIV_PROD_W = 27;
  localparam logic [SDIV_PROD_W-1:0] SDIV_MAGIC = 27'd5243;
  localparam int SDIV_SHIFT = 19;
  localparam int REM_W      = 7;

  localparam logic [SMP_W-1:0] DIVISOR = 32'd100;

  typedef struct packed {
    logic [NSTG-1:0]   ld;
    logic [ADDR_W-1:0] rd_addr;
    logic              stored0;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              bypass;
    logic [PCT_W-1:0]  pct;
    logic              echo_en;
  } fedl_ctl_t;

endpackage

>>> rtl/fedl_if.sv
// Request channel interfaces for the sample input and the echo result.
interface fedl_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [fedl_pkg::SMP_W-1:0]  sample_left;
  logic signed [fedl_pkg::SMP_W-1:0]  sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface fedl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fedl_pkg::SMP_W-1:0]  out_left;
  logic signed [fedl_pkg::SMP_W-1:0]  out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

>>> rtl/feedback_echo_delay_line_unit.sv
// Top level: stereo feedback echo with one lane per channel and a merged output register.
//
//   channel   dir  payload                      handshake
//   in_chan   in   sample_left, sample_right    valid / ready
//   out_chan  out  out_left, out_right          valid / ready
//   cfg       in   cfg_index, cfg_data          cfg_we
//
// Each request passes through six lane stages (store read, magnitude, divide-by-100,
// percent products, final quotient), the last of which loads the output register. One
// request per cycle when delay_length is 7 or more and the output is not held; delays of
// 1 to 6 wait on the pending store write of the same position.
// The stores need no clearing pass: a fill count marks unwritten positions as zero.
// A held output stalls the stages behind it; empty stages still take requests.
module feedback_echo_delay_line_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  fedl_in_if.sink                        in_chan,
  fedl_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [fedl_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fedl_pkg::CFG_W-1:0]     cfg_data
);
  import fedl_pkg::*;

  fedl_ctl_t ctl;
  logic      out_ld;
  logic      out_free;
  logic      out_valid_r;
  logic signed [SMP_W-1:0] out_left_r, out_right_r;
  logic signed [SMP_W-1:0] res_left, res_right;

  assign out_free = !out_valid_r || out_chan.ready;

  fedl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_free  (out_free),
    .out_ld    (out_ld),
    .ctl       (ctl)
  );

  fedl_lane u_lane_left (
    .clk    (clk),
    .ctl    (ctl),
    .sample (in_chan.sample_left),
    .res    (res_left)
  );

  fedl_lane u_lane_right (
    .clk    (clk),
    .ctl    (ctl),
    .sample (in_chan.sample_right),
    .res    (res_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_left_r  <= res_left;
      out_right_r <= res_right;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_left  = out_left_r;
  assign out_chan.out_right = out_right_r;

endmodule

>>> rtl/fedl_ctrl.sv
// Configuration registers, position and fill tracking, pipeline flow and hazard control.
module fedl_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fedl_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [fedl_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             out_free,
  output logic                             out_ld,
  output fedl_pkg::fedl_ctl_t              ctl
);
  import fedl_pkg::*;

  logic [LEN_W-1:0]  len_r;
  logic [PCT_W-1:0]  pct_r;
  logic              en_r;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [NSTG-1:0]   v_r, v_nxt;
  logic [NSTG-1:0]   byp_r;
  logic              stored0_r;
  logic [ADDR_W-1:0] spos_r [NSTG];

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  pos_inc;
  logic              len0;
  logic              stored;
  logic              hazard;
  logic              accept;
  logic              dup_wr;
  logic [NSTG-1:0]   leave;
  logic [NSTG-1:0]   ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= DELAY_LENGTH_RST;
      pct_r <= FEEDBACK_PERCENT_RST;
      en_r  <= ECHO_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY_LENGTH:     len_r <= cfg_data[LEN_W-1:0];
        REG_FEEDBACK_PERCENT: pct_r <= cfg_data[PCT_W-1:0];
        REG_ECHO_ENABLE:      en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign len_eff = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  assign len0    = (len_eff == '0);
  assign pos_inc = {1'b0, pos_r} + LEN_W'(1);
  assign stored  = ({1'b0, pos_r} < fill_r);

  always_comb begin
    hazard = 1'b0;
    dup_wr = 1'b0;
    for (int s = 0; s < NSTG; s++) begin
      if (v_r[s] && !byp_r[s] && (spos_r[s] == pos_r)) hazard = 1'b1;
    end
    for (int s = 0; s < NSTG - 1; s++) begin
      if (v_r[s] && !byp_r[s] && (spos_r[s] == spos_r[NSTG-1])) dup_wr = 1'b1;
    end
  end

  always_comb begin
    out_ld = v_r[NSTG-1] && out_free;
    leave[NSTG-1] = out_ld;
    for (int s = NSTG - 2; s >= 0; s--) begin
      leave[s] = v_r[s] && (!v_r[s+1] || leave[s+1]);
    end
  end

  assign in_ready = rst_n && (!v_r[0] || leave[0]) && !(hazard && !len0);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ld[0] = accept;
    for (int s = 1; s < NSTG; s++) begin
      ld[s] = leave[s-1];
    end
    for (int s = 0; s < NSTG; s++) begin
      if (ld[s]) begin
        v_nxt[s] = 1'b1;
      end else if (leave[s]) begin
        v_nxt[s] = 1'b0;
      end else begin
        v_nxt[s] = v_r[s];
      end
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (accept && !len0) begin
      pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
      if ({1'b0, pos_r} == fill_r) fill_nxt = fill_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      v_r    <= '0;
      byp_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      v_r    <= v_nxt;
      if (ld[0]) byp_r[0] <= len0;
      for (int s = 1; s < NSTG; s++) begin
        if (ld[s]) byp_r[s] <= byp_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      spos_r[0] <= pos_r;
      stored0_r <= stored;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (ld[s]) spos_r[s] <= spos_r[s-1];
    end
  end

  assign ctl.ld      = ld;
  assign ctl.rd_addr = pos_r;
  assign ctl.stored0 = stored0_r;
  assign ctl.wr_en   = out_ld && !byp_r[NSTG-1];
  assign ctl.wr_addr = spos_r[NSTG-1];
  assign ctl.bypass  = byp_r[NSTG-1];
  assign ctl.pct     = pct_r;
  assign ctl.echo_en = en_r;

  a_pos_filled: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} <= fill_r)
    else $error("position ran past the written region");

  a_bypass_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept && len0 |=> $stable(pos_r) && $stable(fill_r))
    else $error("pass-through request moved the position");

  a_write_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> !dup_wr)
    else $error("another request in flight shares the write address");

  a_accept_no_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !len0 |-> !hazard)
    else $error("request accepted over a pending write to its address");

endmodule

>>> rtl/fedl_lane.sv
// One channel lane: delay store, feedback scaling pipeline and saturating add.
module fedl_lane (
  input  logic                              clk,
  input  fedl_pkg::fedl_ctl_t               ctl,
  input  logic signed [fedl_pkg::SMP_W-1:0] sample,
  output logic signed [fedl_pkg::SMP_W-1:0] res
);
  import fedl_pkg::*;

  logic [SMP_W-1:0] mem [MAX_DELAY];

  logic [SMP_W-1:0] rd_r;
  logic [SMP_W-1:0] smp_r [NSTG];

  logic             neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [SMP_W-1:0] m1_r, m2_r;
  logic [Q_W-1:0]   q2_r;
  logic [REM_W-1:0] r3_r;
  logic [SMP_W-1:0] qp3_r, qp4_r;
  logic [RP_W-1:0]  rp4_r;
  logic [SMP_W-1:0] fbm5_r;

  logic [SMP_W-1:0]       d0;
  logic [SMP_W-1:0]       m_nxt;
  logic [DIV_PROD_W-1:0]  q_prod;
  logic [SMP_W-1:0]       q100;
  logic [SMP_W-1:0]       rem;
  logic [SDIV_PROD_W-1:0] rq_prod;
  logic signed [SMP_W+1:0] fb;
  logic signed [SMP_W+1:0] sum;
  logic [SMP_W-1:0]       sat;

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) rd_r <= mem[ctl.rd_addr];
    if (ctl.wr_en) mem[ctl.wr_addr] <= res;
  end

  assign d0      = ctl.stored0 ? rd_r : '0;
  assign m_nxt   = d0[SMP_W-1] ? (~d0 + SMP_W'(1)) : d0;
  assign q_prod  = DIV_PROD_W'(m1_r) * DIV_PROD_W'(DIV_MAGIC);
  assign q100    = SMP_W'(q2_r) * DIVISOR;
  assign rem     = m2_r - q100;
  assign rq_prod = SDIV_PROD_W'(rp4_r) * SDIV_MAGIC;

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) smp_r[0] <= sample;
    for (int s = 1; s < NSTG; s++) begin
      if (ctl.ld[s]) smp_r[s] <= smp_r[s-1];
    end
    if (ctl.ld[1]) begin
      neg1_r <= d0[SMP_W-1];
      m1_r   <= m_nxt;
    end
    if (ctl.ld[2]) begin
      neg2_r <= neg1_r;
      m2_r   <= m1_r;
      q2_r   <= q_prod[DIV_SHIFT+Q_W-1:DIV_SHIFT];
    end
    if (ctl.ld[3]) begin
      neg3_r <= neg2_r;
      r3_r   <= rem[REM_W-1:0];
      qp3_r  <= SMP_W'(q2_r) * SMP_W'(ctl.pct);
    end
    if (ctl.ld[4]) begin
      neg4_r <= neg3_r;
      qp4_r  <= qp3_r;
      rp4_r  <= RP_W'(r3_r) * RP_W'(ctl.pct);
    end
    if (ctl.ld[5]) begin
      neg5_r <= neg4_r;
      fbm5_r <= qp4_r + SMP_W'(rq_prod[SDIV_SHIFT+REM_W-1:SDIV_SHIFT]);
    end
  end

  always_comb begin
    fb  = neg5_r ? -$signed({2'b00, fbm5_r}) : $signed({2'b00, fbm5_r});
    sum = $signed({{2{smp_r[NSTG-1][SMP_W-1]}}, smp_r[NSTG-1]}) + fb;
    if (sum[SMP_W+1:SMP_W-1] == 3'b000 || sum[SMP_W+1:SMP_W-1] == 3'b111) begin
      sat = sum[SMP_W-1:0];
    end else if (sum[SMP_W+1]) begin
      sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
    if (ctl.bypass || !ctl.echo_en) begin
      res = smp_r[NSTG-1];
    end else begin
      res = sat;
    end
  end

endmodule

>>> tb/tb_feedback_echo_delay_line_unit.sv
// Self-checking testbench for the stereo feedback echo: random traffic with echo prediction.

typedef struct packed {
  logic signed [fedl_pkg::SMP_W-1:0] left;
  logic signed [fedl_pkg::SMP_W-1:0] right;
} echo_frame_t;

class echo_scoreboard;
  localparam longint SMP_HI = 64'sd2147483647;
  localparam longint SMP_LO = -SMP_HI - 1;

  logic [fedl_pkg::SMP_W-1:0] left_line [fedl_pkg::MAX_DELAY];
  logic [fedl_pkg::SMP_W-1:0] right_line [fedl_pkg::MAX_DELAY];
  logic [fedl_pkg::LEN_W-1:0] length;
  logic [fedl_pkg::PCT_W-1:0] percent;
  logic                       echo_on;
  int unsigned                position;
  echo_frame_t                pending_echoes [$];
  int                         mismatches;

  function new();
    foreach (left_line[i]) begin
      left_line[i] = '0;
      right_line[i] = '0;
    end
    length = fedl_pkg::DELAY_LENGTH_RST;
    percent = fedl_pkg::FEEDBACK_PERCENT_RST;
    echo_on = fedl_pkg::ECHO_ENABLE_RST;
    position = 0;
    mismatches = 0;
  endfunction

  function void set_register(logic [fedl_pkg::REG_IDX_W-1:0] idx,
                             logic [fedl_pkg::CFG_W-1:0] data);
    case (idx)
      fedl_pkg::REG_DELAY_LENGTH: length = data[fedl_pkg::LEN_W-1:0];
      fedl_pkg::REG_FEEDBACK_PERCENT: percent = data[fedl_pkg::PCT_W-1:0];
      fedl_pkg::REG_ECHO_ENABLE: echo_on = data[0];
      default: ;
    endcase
  endfunction

  function logic signed [fedl_pkg::SMP_W-1:0] mix_echo(logic signed [fedl_pkg::SMP_W-1:0] smp,
                                                      logic signed [fedl_pkg::SMP_W-1:0] dly);
    longint fb;
    longint sum;
    fb = (longint'(dly) * longint'(percent)) / 100;
    sum = longint'(smp) + fb;
    if (!echo_on) return smp;
    if (sum > SMP_HI) return SMP_HI[fedl_pkg::SMP_W-1:0];
    if (sum < SMP_LO) return SMP_LO[fedl_pkg::SMP_W-1:0];
    return sum[fedl_pkg::SMP_W-1:0];
  endfunction

  function void note_request(logic signed [fedl_pkg::SMP_W-1:0] l,
                             logic signed [fedl_pkg::SMP_W-1:0] r);
    echo_frame_t f;
    int unsigned eff_len;
    eff_len = (length > fedl_pkg::MAX_DELAY) ? fedl_pkg::MAX_DELAY : length;
    if (eff_len == 0) begin
      f.left = l;
      f.right = r;
    end else begin
      f.left = mix_echo(l, left_line[position]);
      f.right = mix_echo(r, right_line[position]);
      left_line[position] = f.left;
      right_line[position] = f.right;
      position = position + 1;
      if (position >= eff_len) position = 0;
    end
    pending_echoes.push_back(f);
  endfunction

  function void check_result(logic signed [fedl_pkg::SMP_W-1:0] l,
                             logic signed [fedl_pkg::SMP_W-1:0] r);
    echo_frame_t f;
    if (pending_echoes.size() == 0) begin
      $error("unexpected result: out_left %0d out_right %0d", l, r);
      mismatches++;
      return;
    end
    f = pending_echoes.pop_front();
    if (l !== f.left) begin
      $error("out_left: expected %0d, actual %0d", f.left, l);
      mismatches++;
    end
    if (r !== f.right) begin
      $error("out_right: expected %0d, actual %0d", f.right, r);
      mismatches++;
    end
  endfunction

  function int pending();
    return pending_echoes.size();
  endfunction
endclass

module tb_feedback_echo_delay_line_unit;
  import fedl_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam logic signed [SMP_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SMP_W-1:0] S_MIN = 32'sh80000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  idle_mode_t idle_mode = IDLE_NONE;
  logic       hold_req = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_cnt = 0;
  int         quiet_cycles = 0;

  echo_scoreboard sb;

  fedl_in_if  in_if ();
  fedl_out_if out_if ();

  feedback_echo_delay_line_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_request(in_if.sample_left, in_if.sample_right);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_left, out_if.out_right);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 46) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 8));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return S_MAX - $urandom_range(1000);
      3: return S_MIN + $urandom_range(1000);
      4: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic signed [SMP_W-1:0] l, input logic signed [SMP_W-1:0] r);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 46) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample_left <= l;
    in_if.sample_right <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // drop valid, drain the pipeline, then rewrite every register
  task automatic set_config(input logic [LEN_W-1:0] len, input logic [PCT_W-1:0] pct,
                            input logic en);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_DELAY_LENGTH, CFG_W'(len));
    write_reg(REG_FEEDBACK_PERCENT, CFG_W'(pct));
    write_reg(REG_ECHO_ENABLE, CFG_W'(en));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    logic [PCT_W-1:0] pct;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.sample_left = '0;
    in_if.sample_right = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(S_MAX, S_MIN);
    send_sample(0, -1);
    send_sample(S_MIN, S_MAX);
    send_sample(1, -2);

    set_config(2, 100, 1'b1);
    repeat (4) send_sample(S_MAX, S_MIN);
    send_sample(-1, 1);
    send_sample(-1, 1);

    set_config(1, 127, 1'b1);
    repeat (3) send_sample(1000000007, -1000000007);
    send_sample(-7, 7);

    set_config(3, 127, 1'b0);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());

    set_config(3, 0, 1'b1);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());

    set_config(17'd131071, 50, 1'b1);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);

    set_config(17'd65536, 100, 1'b1);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) len = 17'd65536;
      else if (ph == 1) len = 1;
      else begin
        case ($urandom_range(7))
          0: len = 0;
          1: len = LEN_W'($urandom_range(1, 3));
          2: len = LEN_W'($urandom_range(4, 8));
          3: len = LEN_W'($urandom_range(9, 40));
          4: len = LEN_W'($urandom_range(41, 1000));
          5: len = 17'd131071;
          6: len = LEN_W'($urandom_range(1000, 65536));
          default: len = LEN_W'($urandom_range(65537, 131071));
        endcase
      end
      case ($urandom_range(3))
        0: pct = 0;
        1: pct = 100;
        2: pct = 127;
        default: pct = PCT_W'($urandom_range(127));
      endcase
      set_config(len, pct, $urandom_range(3) != 0);
      idle_mode <= idle_mode_t'(ph % 4);
      repeat (130) send_sample(pick_sample(), pick_sample());
    end

    // hold the output off while requests keep coming
    set_config(9, 60, 1'b1);
    idle_mode <= IDLE_NONE;
    hold_req <= 1'b1;
    repeat (60) send_sample(pick_sample(), pick_sample());

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
